FILE: rtl/abop_pkg.sv
// shared codes, field layout and widths for the bump offset planner
package abop_pkg;

	// opcodes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;
	localparam logic [1:0] OP_LOOKUP = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_INVALID     = 3'd1;
	localparam logic [2:0] ST_FULL        = 3'd2;
	localparam logic [2:0] ST_MISSING     = 3'd3;
	localparam logic [2:0] ST_ARENA_SIZE  = 3'd4;
	localparam logic [2:0] ST_ARENA_ALIGN = 3'd5;

	// configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_ARENA_ATTACHED = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ARENA_BYTES    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ARENA_ALIGN    = 2'd2;

	// field widths
	localparam int OPCODE_W = 2;
	localparam int NODE_TAG_W = 16;
	localparam int WORD_W = 32;
	localparam int STATUS_W = 3;

	// input beat layout
	localparam int IN_OPCODE_LSB = 0;
	localparam int IN_TAG_LSB    = IN_OPCODE_LSB + OPCODE_W;
	localparam int IN_BYTES_LSB  = IN_TAG_LSB + NODE_TAG_W;
	localparam int IN_ALIGN_LSB  = IN_BYTES_LSB + WORD_W;
	localparam int IN_USED_W     = IN_ALIGN_LSB + WORD_W;
	localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

	// output beat layout
	localparam int OUT_STATUS_LSB  = 0;
	localparam int OUT_OFFSET_LSB  = OUT_STATUS_LSB + STATUS_W;
	localparam int OUT_TOTAL_LSB   = OUT_OFFSET_LSB + WORD_W;
	localparam int OUT_LARGEST_LSB = OUT_TOTAL_LSB + WORD_W;
	localparam int OUT_USED_W      = OUT_LARGEST_LSB + WORD_W;
	localparam int OUT_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

endpackage

FILE: rtl/abop_ram.sv
// generic single write port ram with registered read
module abop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                     wr_data,
	input  logic                                 rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                     rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

FILE: rtl/aligned_bump_offset_planner.sv
// top level: bump allocation planner with record table and sequenced shared adder
//
// channel  dir  handshake                  payload
// s_       in   s_tvalid / s_tready        s_tdata: opcode, node_tag, request_bytes, request_align
// m_       out  m_tvalid / m_tready        m_tdata: status, offset, total_bytes, largest_align
// cfg_     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one item at a time; s_tready is high only while the sequencer is idle
// clear, and finish without arena, go straight to the result; finish with arena checks size, then alignment;
// append steps through mask, round, end and max; a failing check ends either item early
// lookup: reads and compares one record at a time (single ram read port, registered read),
// scanning at most MAX_ENTRIES records
// a finished result waits in the output register; the sequencer holds until it is free
// reset clears the plan at once through the record count; no clearing pass
module aligned_bump_offset_planner #(
	parameter int MAX_ENTRIES = 64,
	parameter int ADDR_BITS = 32,
	parameter int TAG_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// opcode, node_tag, request_bytes, request_align (from bit 0 up), zero padded
	input  logic [abop_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// status, offset, total_bytes, largest_align (from bit 0 up), zero padded
	output logic [abop_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [abop_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [abop_pkg::WORD_W-1:0]           cfg_data
);
	import abop_pkg::*;

	localparam int WW = (ADDR_BITS > WORD_W) ? ADDR_BITS : WORD_W;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int REC_W = TAG_BITS + ADDR_BITS;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_A_MASK  = 4'd1;
	localparam logic [3:0] S_A_RND   = 4'd2;
	localparam logic [3:0] S_A_END   = 4'd3;
	localparam logic [3:0] S_A_MAX   = 4'd4;
	localparam logic [3:0] S_F_SIZE  = 4'd5;
	localparam logic [3:0] S_F_ALIGN = 4'd6;
	localparam logic [3:0] S_L_READ  = 4'd7;
	localparam logic [3:0] S_L_CMP   = 4'd8;
	localparam logic [3:0] S_DONE    = 4'd9;

	// control state
	logic [3:0]        state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_BITS-1:0] total_q;
	logic [WORD_W-1:0] max_q;
	logic              arena_attached_q;
	logic [WORD_W-1:0] arena_bytes_q;
	logic [WORD_W-1:0] arena_align_q;
	logic              m_tvalid_q;

	// item payload and working registers
	logic [TAG_BITS-1:0]  tag_q;
	logic [WORD_W-1:0]    size_q;
	logic [WORD_W-1:0]    align_q;
	logic [WW-1:0]        mask_q;
	logic [WW:0]          rnd_q;
	logic [WW:0]          end_q;
	logic [ADDR_BITS-1:0] start_q;
	logic [CNT_W-1:0]     idx_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic [ADDR_BITS-1:0] res_off_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	// shared adder
	logic [WW-1:0] alu_a, alu_b;
	logic          alu_cin;
	logic [WW:0]   alu_sum;

	logic s_accept, out_free;
	logic [OPCODE_W-1:0] op_in;
	logic do_clear, do_commit, res_load, idx_step;
	logic [STATUS_W-1:0]  res_status_d;
	logic [ADDR_BITS-1:0] res_off_d;
	logic bad_req, rnd_ovf, end_ovf, table_full, rec_match, scan_last;
	logic [WW-1:0] start_w;
	logic [CNT_W-1:0] idx_nx;
	logic [REC_W-1:0] rd_data;
	logic [WW-1:0] off_ext, total_ext;

	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign op_in = s_tdata[IN_OPCODE_LSB +: OPCODE_W];
	assign out_free = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign bad_req = (size_q == '0) || (align_q == '0) || ((align_q & mask_q[WORD_W-1:0]) != '0);
	assign rnd_ovf = (rnd_q[WW:ADDR_BITS] != '0);
	assign end_ovf = (end_q[WW:ADDR_BITS] != '0);
	assign table_full = (count_q >= CNT_W'(MAX_ENTRIES));
	assign start_w = rnd_q[WW-1:0] & ~mask_q;
	assign idx_nx = idx_q + CNT_W'(1);
	assign scan_last = (idx_nx == count_q);
	assign rec_match = (rd_data[ADDR_BITS +: TAG_BITS] == tag_q);

	always_comb begin
		alu_a = '0;
		alu_b = '0;
		alu_cin = 1'b0;
		unique case (state_q)
			S_A_MASK: begin
				// align - 1
				alu_a = WW'(align_q);
				alu_b = '1;
			end
			S_A_RND: begin
				alu_a = WW'(total_q);
				alu_b = mask_q;
			end
			S_A_END: begin
				alu_a = start_w;
				alu_b = WW'(size_q);
			end
			S_A_MAX: begin
				// carry set when max >= align
				alu_a = WW'(max_q);
				alu_b = ~WW'(align_q);
				alu_cin = 1'b1;
			end
			S_F_SIZE: begin
				alu_a = WW'(arena_bytes_q);
				alu_b = ~WW'(total_q);
				alu_cin = 1'b1;
			end
			S_F_ALIGN: begin
				alu_a = WW'(arena_align_q);
				alu_b = ~WW'(max_q);
				alu_cin = 1'b1;
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (WW + 1)'(alu_cin);

	always_comb begin
		state_d = state_q;
		do_clear = 1'b0;
		do_commit = 1'b0;
		res_load = 1'b0;
		idx_step = 1'b0;
		res_status_d = ST_OK;
		res_off_d = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_accept) begin
					unique case (op_in)
						OP_CLEAR: begin
							do_clear = 1'b1;
							res_load = 1'b1;
							state_d = S_DONE;
						end
						OP_APPEND: begin
							state_d = S_A_MASK;
						end
						OP_FINISH: begin
							if (arena_attached_q) begin
								state_d = S_F_SIZE;
							end else begin
								res_load = 1'b1;
								state_d = S_DONE;
							end
						end
						default: begin
							if (count_q == '0) begin
								res_load = 1'b1;
								res_status_d = ST_MISSING;
								state_d = S_DONE;
							end else begin
								state_d = S_L_READ;
							end
						end
					endcase
				end
			end
			S_A_MASK: begin
				state_d = S_A_RND;
			end
			S_A_RND: begin
				if (bad_req) begin
					do_clear = 1'b1;
					res_load = 1'b1;
					res_status_d = ST_INVALID;
					state_d = S_DONE;
				end else begin
					state_d = S_A_END;
				end
			end
			S_A_END: begin
				if (rnd_ovf) begin
					do_clear = 1'b1;
					res_load = 1'b1;
					res_status_d = ST_INVALID;
					state_d = S_DONE;
				end else begin
					state_d = S_A_MAX;
				end
			end
			S_A_MAX: begin
				res_load = 1'b1;
				state_d = S_DONE;
				if (end_ovf) begin
					do_clear = 1'b1;
					res_status_d = ST_INVALID;
				end else if (table_full) begin
					do_clear = 1'b1;
					res_status_d = ST_FULL;
				end else begin
					do_commit = 1'b1;
					res_off_d = start_q;
				end
			end
			S_F_SIZE: begin
				if (!alu_sum[WW]) begin
					do_clear = 1'b1;
					res_load = 1'b1;
					res_status_d = ST_ARENA_SIZE;
					state_d = S_DONE;
				end else begin
					state_d = S_F_ALIGN;
				end
			end
			S_F_ALIGN: begin
				res_load = 1'b1;
				state_d = S_DONE;
				if (!alu_sum[WW]) begin
					do_clear = 1'b1;
					res_status_d = ST_ARENA_ALIGN;
				end
			end
			S_L_READ: begin
				state_d = S_L_CMP;
			end
			S_L_CMP: begin
				if (rec_match) begin
					res_load = 1'b1;
					res_off_d = rd_data[ADDR_BITS-1:0];
					state_d = S_DONE;
				end else if (scan_last) begin
					res_load = 1'b1;
					res_status_d = ST_MISSING;
					state_d = S_DONE;
				end else begin
					idx_step = 1'b1;
					state_d = S_L_READ;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
			max_q <= '0;
			arena_attached_q <= 1'b0;
			arena_bytes_q <= '0;
			arena_align_q <= WORD_W'(1);
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_clear) begin
				count_q <= '0;
				total_q <= '0;
				max_q <= '0;
			end else if (do_commit) begin
				count_q <= count_q + CNT_W'(1);
				total_q <= end_q[ADDR_BITS-1:0];
				if (!alu_sum[WW]) begin
					max_q <= align_q;
				end
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ARENA_ATTACHED: arena_attached_q <= cfg_data[0];
					REG_ARENA_BYTES:    arena_bytes_q <= cfg_data;
					REG_ARENA_ALIGN:    arena_align_q <= cfg_data;
					default:            arena_attached_q <= arena_attached_q;
				endcase
			end
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign off_ext = WW'(res_off_q);
	assign total_ext = WW'(total_q);

	always_ff @(posedge clk) begin
		if (s_accept) begin
			tag_q <= TAG_BITS'(s_tdata[IN_TAG_LSB +: NODE_TAG_W]);
			size_q <= s_tdata[IN_BYTES_LSB +: WORD_W];
			align_q <= s_tdata[IN_ALIGN_LSB +: WORD_W];
			idx_q <= '0;
		end else if (idx_step) begin
			idx_q <= idx_nx;
		end
		if (state_q == S_A_MASK) begin
			mask_q <= alu_sum[WW-1:0];
		end
		if (state_q == S_A_RND) begin
			rnd_q <= alu_sum;
		end
		if (state_q == S_A_END) begin
			end_q <= alu_sum;
			start_q <= start_w[ADDR_BITS-1:0];
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_off_q <= res_off_d;
		end
		if (state_q == S_DONE && out_free) begin
			m_tdata_q <= OUT_TDATA_W'({max_q, total_ext[WORD_W-1:0],
				off_ext[WORD_W-1:0], res_status_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// record table: tag above offset
	abop_ram #(
		.WIDTH(REC_W),
		.DEPTH(MAX_ENTRIES)
	) u_records (
		.clk(clk),
		.wr_en(do_commit),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data({tag_q, start_q}),
		.rd_en(state_q == S_L_READ),
		.rd_addr(idx_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("record count beyond table depth");

	a_max_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(max_q))
		else $error("largest alignment is not a power of two");

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[OUT_STATUS_LSB +: STATUS_W] == ST_INVALID
			|| m_tdata[OUT_STATUS_LSB +: STATUS_W] == ST_FULL
			|| m_tdata[OUT_STATUS_LSB +: STATUS_W] == ST_ARENA_SIZE
			|| m_tdata[OUT_STATUS_LSB +: STATUS_W] == ST_ARENA_ALIGN))
		|-> (m_tdata[OUT_TOTAL_LSB +: WORD_W] == '0
			&& m_tdata[OUT_LARGEST_LSB +: WORD_W] == '0))
		else $error("failed item left a nonzero plan");

	a_commit_fits: assert property (@(posedge clk) disable iff (!arst_n)
		do_commit |=> (count_q != '0))
		else $error("append commit did not record an entry");
endmodule

FILE: test/tb_aligned_bump_offset_planner.sv
// self-checking bench for the bump offset planner: directed corners, then random plan sequences
module tb_aligned_bump_offset_planner;
	import abop_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam longint unsigned ADDR_LIMIT = 64'hFFFF_FFFF;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   offset;
		logic [WORD_W-1:0]   total;
		logic [WORD_W-1:0]   largest;
	} plan_result_t;

	class plan_scoreboard;
		bit                    arena_on;
		bit [WORD_W-1:0]       arena_cap;
		bit [WORD_W-1:0]       arena_guar;
		bit [NODE_TAG_W-1:0]   rec_tag [TABLE_DEPTH];
		bit [WORD_W-1:0]       rec_off [TABLE_DEPTH];
		int unsigned           rec_count;
		bit [WORD_W-1:0]       plan_total;
		bit [WORD_W-1:0]       plan_largest;
		plan_result_t          expected_results [$];
		int unsigned           mismatches;

		function new();
			arena_on = 0;
			arena_cap = '0;
			arena_guar = 32'd1;
			wipe_plan();
			mismatches = 0;
		endfunction

		function void wipe_plan();
			rec_count = 0;
			plan_total = '0;
			plan_largest = '0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [WORD_W-1:0] data);
			case (idx)
				REG_ARENA_ATTACHED: arena_on = data[0];
				REG_ARENA_BYTES:    arena_cap = data;
				REG_ARENA_ALIGN:    arena_guar = data;
				default: ;
			endcase
		endfunction

		function plan_result_t predict_plan_step(bit [OPCODE_W-1:0] op, bit [NODE_TAG_W-1:0] tag,
				bit [WORD_W-1:0] size, bit [WORD_W-1:0] align);
			plan_result_t r;
			longint unsigned mask, start;
			bit found;
			r.status = ST_OK;
			r.offset = '0;
			case (op)
				OP_CLEAR: wipe_plan();
				OP_APPEND: begin
					if (size == 0 || align == 0 || (align & (align - 32'd1)) != 0) begin
						r.status = ST_INVALID;
					end else begin
						mask = longint'(align) - 1;
						start = (longint'(plan_total) + mask) & ~mask;
						if (mask > ADDR_LIMIT - plan_total)
							r.status = ST_INVALID;
						else if (longint'(size) > ADDR_LIMIT - start)
							r.status = ST_INVALID;
						else if (rec_count >= TABLE_DEPTH)
							r.status = ST_FULL;
						else begin
							rec_tag[rec_count] = tag;
							rec_off[rec_count] = start[WORD_W-1:0];
							rec_count++;
							plan_total = WORD_W'(start + size);
							if (align > plan_largest)
								plan_largest = align;
							r.offset = start[WORD_W-1:0];
						end
					end
					if (r.status != ST_OK)
						wipe_plan();
				end
				OP_FINISH: begin
					if (arena_on) begin
						if (plan_total > arena_cap)
							r.status = ST_ARENA_SIZE;
						else if (plan_largest > arena_guar)
							r.status = ST_ARENA_ALIGN;
						if (r.status != ST_OK)
							wipe_plan();
					end
				end
				OP_LOOKUP: begin
					found = 0;
					r.status = ST_MISSING;
					for (int i = 0; i < rec_count && !found; i++) begin
						if (rec_tag[i] == tag) begin
							found = 1;
							r.status = ST_OK;
							r.offset = rec_off[i];
						end
					end
				end
			endcase
			r.total = plan_total;
			r.largest = plan_largest;
			return r;
		endfunction

		function void note_request(logic [IN_TDATA_W-1:0] beat);
			expected_results.push_back(predict_plan_step(beat[IN_OPCODE_LSB +: OPCODE_W],
				beat[IN_TAG_LSB +: NODE_TAG_W], beat[IN_BYTES_LSB +: WORD_W],
				beat[IN_ALIGN_LSB +: WORD_W]));
		endfunction

		task report(string what);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		task check_result(logic [OUT_TDATA_W-1:0] beat);
			plan_result_t want;
			logic [STATUS_W-1:0] got_status;
			logic [WORD_W-1:0] got_offset, got_total, got_largest;
			if (expected_results.size() == 0) begin
				report($sformatf("result beat %h with no request waiting", beat));
				return;
			end
			want = expected_results.pop_front();
			got_status = beat[OUT_STATUS_LSB +: STATUS_W];
			got_offset = beat[OUT_OFFSET_LSB +: WORD_W];
			got_total = beat[OUT_TOTAL_LSB +: WORD_W];
			got_largest = beat[OUT_LARGEST_LSB +: WORD_W];
			if (got_status !== want.status)
				report($sformatf("status got %0d want %0d", got_status, want.status));
			if (got_offset !== want.offset)
				report($sformatf("offset got %h want %h", got_offset, want.offset));
			if (got_total !== want.total)
				report($sformatf("total_bytes got %h want %h", got_total, want.total));
			if (got_largest !== want.largest)
				report($sformatf("largest_align got %h want %h", got_largest, want.largest));
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_TDATA_W-1:0]   s_tdata = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0]  m_tdata;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [WORD_W-1:0]       cfg_data = '0;

	plan_scoreboard sb = new();
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned burst_left = 0;

	aligned_bump_offset_planner dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// all beats are observed here; results first so the queue head is the older item
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
				results_seen++;
			end
			if (s_tvalid && s_tready)
				sb.note_request(s_tdata);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	// receiver: a stall pattern picked at random from four modes and redrawn as the run goes, plus one long hold-off
	initial begin
		int unsigned cyc;
		int unsigned rx_mode;
		bit held_off;
		cyc = 0;
		rx_mode = 0;
		held_off = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && results_seen >= 150) begin
				held_off = 1;
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			cyc++;
			if (cyc % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) == 0);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((cyc % 7) < 3);
			endcase
		end
	end

	initial begin
		#3000000;
		$display("** aligned_bump_offset_planner: FAILED **");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the beat was taken
	task send_item(bit [OPCODE_W-1:0] op, bit [NODE_TAG_W-1:0] tag, bit [WORD_W-1:0] size,
			bit [WORD_W-1:0] align);
		logic [IN_TDATA_W-1:0] beat;
		int unsigned gap;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
		beat = '0;
		beat[IN_OPCODE_LSB +: OPCODE_W] = op;
		beat[IN_TAG_LSB +: NODE_TAG_W] = tag;
		beat[IN_BYTES_LSB +: WORD_W] = size;
		beat[IN_ALIGN_LSB +: WORD_W] = align;
		s_tdata <= beat;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	// stop sending and wait until every outstanding result has come back
	task settle();
		s_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(negedge clk);
	endtask

	task write_arena(bit on, bit [WORD_W-1:0] cap, bit [WORD_W-1:0] guar);
		logic [CFG_INDEX_W-1:0] regs [3];
		logic [WORD_W-1:0] vals [3];
		regs[0] = REG_ARENA_ATTACHED;
		regs[1] = REG_ARENA_BYTES;
		regs[2] = REG_ARENA_ALIGN;
		vals[0] = {31'd0, on};
		vals[1] = cap;
		vals[2] = guar;
		for (int i = 0; i < 3; i++) begin
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	task run_sequence();
		int unsigned pick, n;
		bit [NODE_TAG_W-1:0] used_tags [$];
		bit [NODE_TAG_W-1:0] t;
		bit [WORD_W-1:0] size, align;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			// noise: any opcode, fully random fields
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				send_item(OPCODE_W'($urandom_range(0, 3)), NODE_TAG_W'($urandom()),
					$urandom(), $urandom());
		end else if (pick < 19) begin
			// fill the record table to around its capacity
			send_item(OP_CLEAR, NODE_TAG_W'($urandom()), $urandom(), $urandom());
			n = $urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 4);
			for (int i = 0; i < n; i++) begin
				send_item(OP_APPEND, NODE_TAG_W'($urandom_range(0, 255)), $urandom_range(1, 64),
					32'd1 << $urandom_range(0, 4));
				if ($urandom_range(0, 7) == 0)
					send_item(OP_LOOKUP, NODE_TAG_W'($urandom_range(0, 255)), $urandom(),
						$urandom());
			end
			send_item(OP_FINISH, NODE_TAG_W'($urandom()), $urandom(), $urandom());
		end else begin
			if ($urandom_range(0, 1) == 0)
				send_item(OP_CLEAR, NODE_TAG_W'($urandom()), $urandom(), $urandom());
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) < 7)
					t = NODE_TAG_W'($urandom_range(0, 7));
				else
					t = NODE_TAG_W'($urandom());
				case ($urandom_range(0, 19))
					0: begin
						size = $urandom();
						align = 32'd1 << $urandom_range(0, 31);
					end
					1: begin
						size = $urandom_range(0, 64);
						align = $urandom();
					end
					default: begin
						size = $urandom_range(1, 1024);
						align = 32'd1 << $urandom_range(0, 8);
					end
				endcase
				send_item(OP_APPEND, t, size, align);
				used_tags.push_back(t);
				if ($urandom_range(0, 2) == 0) begin
					if ($urandom_range(0, 2) != 0)
						t = used_tags[$urandom_range(0, used_tags.size() - 1)];
					else
						t = NODE_TAG_W'($urandom());
					send_item(OP_LOOKUP, t, $urandom(), $urandom());
				end
			end
			if ($urandom_range(0, 4) != 0)
				send_item(OP_FINISH, NODE_TAG_W'($urandom()), $urandom(), $urandom());
		end
	endtask

	initial begin
		int unsigned phase_start;
		bit on;
		bit [WORD_W-1:0] cap, guar;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no arena: lookups, duplicate tags, bad requests, address range edges
		send_item(OP_LOOKUP, 16'h0000, 32'd0, 32'd0);
		send_item(OP_FINISH, 16'h0000, 32'd0, 32'd0);
		send_item(OP_APPEND, 16'hFFFF, 32'd1, 32'd1);
		send_item(OP_APPEND, 16'h0000, 32'd3, 32'd8);
		send_item(OP_APPEND, 16'hFFFF, 32'd5, 32'd4);
		send_item(OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_LOOKUP, 16'h0000, 32'd0, 32'd0);
		send_item(OP_LOOKUP, 16'h5A5A, 32'd0, 32'd0);
		send_item(OP_FINISH, 16'h0000, 32'd0, 32'd0);
		send_item(OP_APPEND, 16'd7, 32'd0, 32'd4);
		send_item(OP_APPEND, 16'd7, 32'd16, 32'd0);
		send_item(OP_APPEND, 16'd7, 32'd16, 32'd6);
		send_item(OP_APPEND, 16'd7, 32'd16, 32'hFFFF_FFFF);
		send_item(OP_APPEND, 16'd1, 32'hFFFF_FFFF, 32'd1);
		send_item(OP_APPEND, 16'd2, 32'd1, 32'd1);
		send_item(OP_APPEND, 16'd3, 32'h10, 32'h8000_0000);
		send_item(OP_APPEND, 16'd4, 32'd1, 32'h8000_0000);
		send_item(OP_APPEND, 16'd5, 32'h8000_0000, 32'd1);
		send_item(OP_APPEND, 16'd6, 32'h10, 32'd1);
		send_item(OP_APPEND, 16'd7, 32'd1, 32'h8000_0000);
		// rounding the total up runs past the address range
		send_item(OP_APPEND, 16'd8, 32'd1, 32'h8000_0000);
		send_item(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		settle();

		// arena attached: pass, size overrun, alignment overrun, exact fit
		write_arena(1'b1, 32'h100, 32'd16);
		send_item(OP_APPEND, 16'd9, 32'h80, 32'd16);
		send_item(OP_FINISH, 16'd0, 32'd0, 32'd0);
		send_item(OP_APPEND, 16'd10, 32'h100, 32'd4);
		send_item(OP_FINISH, 16'd0, 32'd0, 32'd0);
		send_item(OP_APPEND, 16'd11, 32'd4, 32'd32);
		send_item(OP_FINISH, 16'd0, 32'd0, 32'd0);
		send_item(OP_APPEND, 16'd12, 32'h100, 32'd16);
		send_item(OP_FINISH, 16'd0, 32'd0, 32'd0);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					on = 1'b1;
					cap = 32'd0;
					guar = 32'd1;
				end
				1: begin
					on = 1'b1;
					cap = 32'hFFFF_FFFF;
					guar = 32'h8000_0000;
				end
				2, 5: begin
					on = 1'b0;
					cap = $urandom();
					guar = 32'd1 << $urandom_range(0, 31);
				end
				default: begin
					on = 1'b1;
					cap = $urandom_range(0, 20000);
					guar = 32'd1 << $urandom_range(0, 10);
				end
			endcase
			write_arena(on, cap, guar);
			phase_start = items_sent;
			while (items_sent - phase_start < 300)
				run_sequence();
			settle();
		end

		repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
		if (sb.expected_results.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.expected_results.size()));
		if (sb.mismatches == 0)
			$display("** aligned_bump_offset_planner: PASSED **");
		else
			$display("** aligned_bump_offset_planner: FAILED **");
		$finish;
	end

endmodule
